@@ design/dnv_pkg.sv @@
// ----------------------------------------------------------------------------
// Dotted name validator package
// Shared constants and character classes for the dotted name validator.
// ----------------------------------------------------------------------------
package dnv_pkg;

  localparam int unsigned CharWidth       = 8;
  localparam int unsigned NameLenWidth    = 8;
  localparam int unsigned LabelLenWidth   = 7;
  localparam int unsigned LabelCfgWidth   = 6;
  localparam int unsigned LabelCountWidth = 8;
  localparam int unsigned CfgIndexWidth   = 2;
  localparam int unsigned CfgDataWidth    = 8;

  localparam logic [CfgIndexWidth-1:0] REG_MAX_NAME_LENGTH  = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_MAX_LABEL_LENGTH = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_MIN_LABEL_COUNT  = 2'd2;

  localparam logic [NameLenWidth-1:0]    RST_MAX_NAME_LENGTH  = 8'd191;
  localparam logic [LabelCfgWidth-1:0]   RST_MAX_LABEL_LENGTH = 6'd63;
  localparam logic [LabelCountWidth-1:0] RST_MIN_LABEL_COUNT  = 8'd2;

  localparam logic [NameLenWidth-1:0]    TOTAL_MAX       = 8'd255;
  localparam logic [LabelLenWidth-1:0]   LABEL_LEN_MAX   = 7'd127;
  localparam logic [LabelCountWidth-1:0] LABEL_TOTAL_MAX = 8'd255;

  localparam logic [CharWidth-1:0] CHAR_DOT    = 8'h2E;
  localparam logic [CharWidth-1:0] CHAR_HYPHEN = 8'h2D;

  function automatic logic is_alnum(input logic [CharWidth-1:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h30) && (c <= 8'h39));
  endfunction

endpackage

@@ design/dotted_name_validator.sv @@
// ----------------------------------------------------------------------------
// Dotted name validator
// Checks a dotted name, one character per word, against label and length
// rules, and gives one valid bit after the last character.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake           | payload
//   in       | sink      | in_valid / in_stall | char_code, is_last
//   out      | source    | out_valid/out_stall | name_valid
//   cfg      | sink      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One character is taken per cycle while in_stall is low; a word passes an input
// register and the checking logic, and the result is registered and offered
// once the last character has left the input register.
// Reset is synchronous and returns the configuration, counter and valid registers to their defaults.
// The input stalls only while a final character waits behind a stalled result.
// ----------------------------------------------------------------------------
module dotted_name_validator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [dnv_pkg::CharWidth-1:0]      char_code,
  input  logic                               is_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               name_valid,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dnv_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [dnv_pkg::CfgDataWidth-1:0]   cfg_data
);
  import dnv_pkg::*;

  logic [NameLenWidth-1:0]    max_name_length;
  logic [LabelCfgWidth-1:0]   max_label_length;
  logic [LabelCountWidth-1:0] min_label_count;

  logic                       in_reg_valid;
  logic [CharWidth-1:0]       in_reg_char;
  logic                       in_reg_last;

  logic [NameLenWidth-1:0]    total_count;
  logic [LabelLenWidth-1:0]   label_length;
  logic [LabelCountWidth-1:0] label_total;
  logic                       prev_hyphen;
  logic                       error_seen;

  logic [NameLenWidth-1:0]    total_count_next;
  logic [LabelLenWidth-1:0]   label_length_next;
  logic [LabelCountWidth-1:0] label_total_next;
  logic                       prev_hyphen_next;
  logic                       error_seen_next;
  logic                       name_valid_next;
  logic [LabelLenWidth-1:0]   label_inc;
  logic [LabelCountWidth-1:0] label_count;
  logic                       hyphen;
  logic                       final_error;
  logic                       advance;

  assign cfg_ready = 1'b1;
  assign in_stall  = in_reg_valid && in_reg_last && out_valid && out_stall;
  assign advance   = in_reg_valid && !in_stall;

  always_comb begin
    total_count_next  = total_count;
    label_length_next = label_length;
    label_total_next  = label_total;
    prev_hyphen_next  = prev_hyphen;
    error_seen_next   = error_seen;
    hyphen            = (in_reg_char == CHAR_HYPHEN);
    label_inc         = (label_length < LABEL_LEN_MAX) ? label_length + 7'd1 : label_length;

    if (total_count >= TOTAL_MAX) begin
      error_seen_next = 1'b1;
    end else begin
      total_count_next = total_count + 8'd1;
    end

    if (in_reg_char == CHAR_DOT) begin
      if ((label_length == '0) || prev_hyphen) begin
        error_seen_next = 1'b1;
      end
      if (label_total < LABEL_TOTAL_MAX) begin
        label_total_next = label_total + 8'd1;
      end
      label_length_next = '0;
      prev_hyphen_next  = 1'b0;
    end else if (is_alnum(in_reg_char) || hyphen) begin
      if (hyphen && (label_length == '0)) begin
        error_seen_next = 1'b1;
      end
      label_length_next = label_inc;
      if (label_inc > {1'b0, max_label_length}) begin
        error_seen_next = 1'b1;
      end
      prev_hyphen_next = hyphen;
    end else begin
      error_seen_next = 1'b1;
    end

    final_error = error_seen_next || (label_length_next == '0) || prev_hyphen_next;
    label_count = (label_total_next < LABEL_TOTAL_MAX) ? label_total_next + 8'd1
                                                       : LABEL_TOTAL_MAX;
    name_valid_next = !final_error && (total_count_next <= max_name_length) &&
                      (label_count >= min_label_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_name_length  <= RST_MAX_NAME_LENGTH;
      max_label_length <= RST_MAX_LABEL_LENGTH;
      min_label_count  <= RST_MIN_LABEL_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_NAME_LENGTH:  max_name_length  <= cfg_data;
        REG_MAX_LABEL_LENGTH: max_label_length <= cfg_data[LabelCfgWidth-1:0];
        REG_MIN_LABEL_COUNT:  min_label_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      in_reg_char <= char_code;
      in_reg_last <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_count  <= '0;
      label_length <= '0;
      label_total  <= '0;
      prev_hyphen  <= 1'b0;
      error_seen   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (advance && in_reg_last) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        if (in_reg_last) begin
          total_count  <= '0;
          label_length <= '0;
          label_total  <= '0;
          prev_hyphen  <= 1'b0;
          error_seen   <= 1'b0;
        end else begin
          total_count  <= total_count_next;
          label_length <= label_length_next;
          label_total  <= label_total_next;
          prev_hyphen  <= prev_hyphen_next;
          error_seen   <= error_seen_next;
        end
      end
    end
    if (advance && in_reg_last) begin
      name_valid <= name_valid_next;
    end
  end

endmodule

@@ design/dnv_checker.sv @@
// ----------------------------------------------------------------------------
// Dotted name validator checker
// Port-level assertions for the dotted name validator, bound to the top level.
// ----------------------------------------------------------------------------
module dnv_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic name_valid,
  input logic cfg_valid,
  input logic cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("A stalled result word was withdrawn.");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(name_valid))
    else $error("A stalled result word changed.");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("The input stalled without a stalled result.");

  a_reset_free: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_stall && !out_valid && cfg_ready)
    else $error("The block was not idle after reset.");

  a_cfg_taken: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("A register write word was held off.");

endmodule

bind dotted_name_validator dnv_checker u_dnv_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .name_valid (name_valid),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);
